// ===== rtl/cma_pkg.sv =====
package cma_pkg;

    localparam int MAX_CLASSES       = 16;
    localparam int COUNT_WIDTH       = 32;
    localparam int STORE_DEPTH       = MAX_CLASSES * MAX_CLASSES;
    localparam int IDX_WIDTH         = $clog2(STORE_DEPTH);
    localparam int LABEL_WIDTH       = 8;
    localparam int PROD_WIDTH        = 2 * LABEL_WIDTH;
    localparam int OUT_WIDTH         = 32;
    localparam int NUM_CLASSES_WIDTH = 5;
    localparam int QUEUE_DEPTH       = 4;

    localparam logic [LABEL_WIDTH-1:0]       NO_DATA_LABEL     = 8'd255;
    localparam logic [NUM_CLASSES_WIDTH-1:0] NUM_CLASSES_RESET = 5'd16;

    typedef enum logic [1:0] {
        CMD_RECORD       = 2'd0,
        CMD_READ         = 2'd1,
        CMD_CLEAR_ENTRY  = 2'd2,
        CMD_CLEAR_TOTALS = 2'd3
    } command_t;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_NODATA = 2'd1,
        ST_RANGE  = 2'd2
    } status_t;

    typedef logic [COUNT_WIDTH-1:0] count_t;

    typedef struct packed {
        command_t             cmd;
        status_t              status;
        logic [IDX_WIDTH-1:0] idx;
        logic                 labels_equal;
    } work_t;

    function automatic count_t sat_inc(input count_t v);
        return (v == '1) ? v : v + count_t'(1);
    endfunction

    function automatic logic [OUT_WIDTH-1:0] to_out(input count_t v);
        logic [63:0] wide;
        wide = 64'(v);
        return wide[OUT_WIDTH-1:0];
    endfunction

endpackage

// ===== rtl/cma_ram.sv =====
module cma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/cma_front.sv =====
module cma_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [cma_pkg::NUM_CLASSES_WIDTH-1:0] cfg_wdata,
    input  logic [1:0]                            command,
    input  logic [cma_pkg::LABEL_WIDTH-1:0]       truth_label,
    input  logic [cma_pkg::LABEL_WIDTH-1:0]       class_label,
    output cma_pkg::work_t                        work
);

    logic [cma_pkg::NUM_CLASSES_WIDTH-1:0] num_classes_reg;
    logic [cma_pkg::LABEL_WIDTH-1:0]       limit;
    logic                                  truth_ok;
    logic                                  class_ok;
    logic [cma_pkg::PROD_WIDTH-1:0]        flat;
    cma_pkg::command_t                     cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_classes_reg <= cma_pkg::NUM_CLASSES_RESET;
        end
        else if (cfg_we)
        begin
            num_classes_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        cmd = cma_pkg::command_t'(command);
        if (cma_pkg::LABEL_WIDTH'(num_classes_reg) > cma_pkg::LABEL_WIDTH'(cma_pkg::MAX_CLASSES))
        begin
            limit = cma_pkg::LABEL_WIDTH'(cma_pkg::MAX_CLASSES);
        end
        else
        begin
            limit = cma_pkg::LABEL_WIDTH'(num_classes_reg);
        end
        truth_ok = (truth_label != '0) && (truth_label <= limit);
        class_ok = (class_label != '0) && (class_label <= limit);
        flat = cma_pkg::PROD_WIDTH'(truth_label - 1'b1)
               * cma_pkg::PROD_WIDTH'(cma_pkg::MAX_CLASSES)
               + cma_pkg::PROD_WIDTH'(class_label - 1'b1);

        work.cmd          = cmd;
        work.idx          = flat[cma_pkg::IDX_WIDTH-1:0];
        work.labels_equal = (truth_label == class_label);
        if (cmd == cma_pkg::CMD_CLEAR_TOTALS)
        begin
            work.status = cma_pkg::ST_DONE;
        end
        else if (cmd == cma_pkg::CMD_RECORD && truth_label == cma_pkg::NO_DATA_LABEL)
        begin
            work.status = cma_pkg::ST_NODATA;
        end
        else if (!truth_ok || !class_ok)
        begin
            work.status = cma_pkg::ST_RANGE;
        end
        else
        begin
            work.status = cma_pkg::ST_DONE;
        end
    end

endmodule

// ===== rtl/cma_queue.sv =====
module cma_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  cma_pkg::work_t push_data,
    input  logic           pop,
    output cma_pkg::work_t head,
    output logic           empty,
    output logic           full
);

    localparam int PTR_WIDTH = $clog2(cma_pkg::QUEUE_DEPTH);
    localparam int CNT_WIDTH = $clog2(cma_pkg::QUEUE_DEPTH + 1);

    cma_pkg::work_t         slots_reg [cma_pkg::QUEUE_DEPTH];
    logic [PTR_WIDTH-1:0]   wr_ptr_reg;
    logic [PTR_WIDTH-1:0]   rd_ptr_reg;
    logic [CNT_WIDTH-1:0]   count_reg;

    function automatic logic [PTR_WIDTH-1:0] bump(input logic [PTR_WIDTH-1:0] p);
        return (p == PTR_WIDTH'(cma_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign head  = slots_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_WIDTH'(cma_pkg::QUEUE_DEPTH));

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/cma_back.sv =====
module cma_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  cma_pkg::work_t                  head,
    input  logic                            empty,
    output logic                            pop,
    output logic                            done,
    output logic [1:0]                      status,
    output logic [cma_pkg::OUT_WIDTH-1:0]   entry_count,
    output logic [cma_pkg::OUT_WIDTH-1:0]   counted_total,
    output logic [cma_pkg::OUT_WIDTH-1:0]   matched_total,
    output logic                            is_match
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t                            state_reg;
    cma_pkg::work_t                    op_reg;
    logic [cma_pkg::STORE_DEPTH-1:0]   valid_reg;
    logic                              hit_reg;
    cma_pkg::count_t                   pixel_reg;
    cma_pkg::count_t                   pixel_next;
    cma_pkg::count_t                   match_reg;
    cma_pkg::count_t                   match_next;
    cma_pkg::count_t                   entry_reg;
    cma_pkg::count_t                   rdata;
    cma_pkg::count_t                   old_entry;
    cma_pkg::count_t                   new_entry;
    logic                              done_reg;
    cma_pkg::status_t                  status_reg;
    logic                              is_match_reg;
    logic                              active;
    logic                              record;
    logic                              ram_we;

    assign pop = (state_reg == S_IDLE) && !empty;

    cma_ram #(
        .WIDTH(cma_pkg::COUNT_WIDTH),
        .DEPTH(cma_pkg::STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (op_reg.idx),
        .wdata (new_entry),
        .re    (pop),
        .raddr (head.idx),
        .rdata (rdata)
    );

    always_comb
    begin
        old_entry = hit_reg ? rdata : '0;
        active    = (op_reg.status == cma_pkg::ST_DONE)
                    && (op_reg.cmd != cma_pkg::CMD_CLEAR_TOTALS);
        record    = active && (op_reg.cmd == cma_pkg::CMD_RECORD);
        case (op_reg.cmd)
            cma_pkg::CMD_RECORD:      new_entry = cma_pkg::sat_inc(old_entry);
            cma_pkg::CMD_CLEAR_ENTRY: new_entry = '0;
            default:                  new_entry = old_entry;
        endcase
        ram_we = (state_reg == S_EXEC) && active
                 && (op_reg.cmd == cma_pkg::CMD_RECORD
                     || op_reg.cmd == cma_pkg::CMD_CLEAR_ENTRY);
        if (op_reg.cmd == cma_pkg::CMD_CLEAR_TOTALS)
        begin
            pixel_next = '0;
            match_next = '0;
        end
        else
        begin
            pixel_next = record ? cma_pkg::sat_inc(pixel_reg) : pixel_reg;
            match_next = (record && op_reg.labels_equal) ? cma_pkg::sat_inc(match_reg)
                                                         : match_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            op_reg       <= '0;
            valid_reg    <= '0;
            hit_reg      <= 1'b0;
            pixel_reg    <= '0;
            match_reg    <= '0;
            entry_reg    <= '0;
            done_reg     <= 1'b0;
            status_reg   <= cma_pkg::ST_DONE;
            is_match_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (!empty)
                    begin
                        op_reg    <= head;
                        hit_reg   <= valid_reg[head.idx];
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (ram_we)
                    begin
                        valid_reg[op_reg.idx] <= 1'b1;
                    end
                    pixel_reg    <= pixel_next;
                    match_reg    <= match_next;
                    entry_reg    <= active ? new_entry : '0;
                    status_reg   <= op_reg.status;
                    is_match_reg <= record && op_reg.labels_equal;
                    done_reg     <= 1'b1;
                    state_reg    <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign entry_count   = cma_pkg::to_out(entry_reg);
    assign counted_total = cma_pkg::to_out(pixel_reg);
    assign matched_total = cma_pkg::to_out(match_reg);
    assign is_match      = is_match_reg;

    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == S_EXEC))
        else $error("Result strobe without a preceding execute cycle.");

    a_exec_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EXEC |=> state_reg == S_IDLE)
        else $error("Execute state lasted more than one cycle.");

    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && status_reg != cma_pkg::ST_DONE |-> entry_reg == '0 && !is_match_reg)
        else $error("Rejected word reported an entry or a match.");

    a_match_counted: assert property (@(posedge clk) disable iff (!rst_n)
        is_match_reg |-> match_reg != '0 && pixel_reg != '0)
        else $error("Match reported with an empty total.");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> state_reg == S_EXEC && op_reg.status == cma_pkg::ST_DONE)
        else $error("Matrix written outside a valid execute cycle.");

endmodule

// ===== rtl/confusion_matrix_accumulator.sv =====
// Confusion matrix accumulator with a command interface.
// A word is accepted at a rising edge with start high and busy low. It carries
// a command (record pixel, read entry, clear entry, clear totals) and a truth
// and class label. The user must write the class count register through cfg_we
// and cfg_wdata only while the block is idle; the block does not enforce this.
// Each accepted word gives exactly one result, shown for one cycle with done
// high: status, entry_count, counted_total, matched_total and is_match.
// Accepted words wait in a four-entry queue in front of the execution unit.
// In its idle state the unit pops a word and reads the matrix entry from the
// store; in its execute state it updates the entry and registers the result.
// The unit takes the next word only once it is back in its idle state, while
// the queue keeps accepting words. busy rises only when the queue is full.
// Reset clears the totals, the queue and the per-entry valid flags, so every
// matrix entry reads as zero right after reset; the class count resets to 16.
// The receiver cannot stall: every result must be taken in its strobe cycle.
module confusion_matrix_accumulator (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [cma_pkg::NUM_CLASSES_WIDTH-1:0] cfg_wdata,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [1:0]                            command,
    input  logic [cma_pkg::LABEL_WIDTH-1:0]       truth_label,
    input  logic [cma_pkg::LABEL_WIDTH-1:0]       class_label,
    output logic                                  done,
    output logic [1:0]                            status,
    output logic [cma_pkg::OUT_WIDTH-1:0]         entry_count,
    output logic [cma_pkg::OUT_WIDTH-1:0]         counted_total,
    output logic [cma_pkg::OUT_WIDTH-1:0]         matched_total,
    output logic                                  is_match
);

    cma_pkg::work_t work;
    cma_pkg::work_t head;
    logic           q_full;
    logic           q_empty;
    logic           q_pop;
    logic           accept;

    assign busy   = q_full;
    assign accept = start && !q_full;

    cma_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .command     (command),
        .truth_label (truth_label),
        .class_label (class_label),
        .work        (work)
    );

    cma_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (work),
        .pop       (q_pop),
        .head      (head),
        .empty     (q_empty),
        .full      (q_full)
    );

    cma_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .empty         (q_empty),
        .pop           (q_pop),
        .done          (done),
        .status        (status),
        .entry_count   (entry_count),
        .counted_total (counted_total),
        .matched_total (matched_total),
        .is_match      (is_match)
    );

endmodule
